// ===== rtl/core/mi3_pkg.sv =====
// mi3_pkg: shared constants, cofactor index tables and sideband type
// for the 3x3 fixed-point matrix inverse. No dependencies.
package mi3_pkg;

   localparam int FRAC_BITS_DEF  = 16;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int PORT_W         = 32;
   localparam int LANES          = 9;

   // adj[k] = m[a]*m[b] - m[c]*m[d], elements numbered row-major
   localparam int COF_IDX [LANES][4] = '{
      '{8, 4, 7, 5}, '{7, 2, 8, 1}, '{5, 1, 4, 2},
      '{6, 5, 8, 3}, '{8, 0, 6, 2}, '{3, 2, 5, 0},
      '{7, 3, 6, 4}, '{6, 1, 7, 0}, '{4, 0, 3, 1}
   };

   // elements paired with adj[0..2] in the determinant (first column)
   localparam int DET_IDX [3] = '{0, 3, 6};

   typedef struct packed {
      logic             valid;
      logic             singular;
      logic [LANES-1:0] neg;
   } mi3_ctl_type;

endpackage

// ===== rtl/core/mi3_div_pipe.sv =====
// mi3_div_pipe: nine-lane pipelined restoring divider, one quotient bit
// per stage plus an overflow check stage. Depends on mi3_pkg.
module mi3_div_pipe #(
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  mi3_pkg::mi3_ctl_type      ctl_in,
   input  logic [3*DATA_WIDTH-1:0]   dmag_in,
   input  logic [2*DATA_WIDTH-1:0]   num_in  [mi3_pkg::LANES],
   output mi3_pkg::mi3_ctl_type      ctl_out,
   output logic [DATA_WIDTH:0]       quo_out [mi3_pkg::LANES],
   output logic [mi3_pkg::LANES-1:0] ovf_out
);

   localparam int DW   = DATA_WIDTH;
   localparam int QB   = DW + 1;
   localparam int MW   = 3 * DW;
   localparam int RW_A = 4 * DW + 1;
   localparam int RW_B = 2 * DW + 2 * FRAC_BITS;
   localparam int RW   = ((RW_A > RW_B) ? RW_A : RW_B) + 1;
   localparam int L    = mi3_pkg::LANES;

   mi3_pkg::mi3_ctl_type ctl_ff  [QB+1];
   logic [MW-1:0]        dmag_ff [QB];
   logic [RW-1:0]        rem_ff  [QB+1][L];
   logic [QB-1:0]        quo_ff  [QB+1][L];
   logic [L-1:0]         ovf_ff  [QB+1];

   // stage 0: scale numerator, flag quotients that need more than QB bits
   logic [RW-1:0] rem0_in [L];
   logic [L-1:0]  ovf0_in;

   always_comb begin
      for (int k = 0; k < L; k++) begin
         rem0_in[k] = RW'(num_in[k]) << (2 * FRAC_BITS);
         ovf0_in[k] = rem0_in[k] >= (RW'(dmag_in) << QB);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (enable) begin
         ctl_ff[0] <= ctl_in;
      end
      if (enable) begin
         dmag_ff[0] <= dmag_in;
         ovf_ff[0]  <= ovf0_in;
         for (int k = 0; k < L; k++) begin
            rem_ff[0][k] <= rem0_in[k];
            quo_ff[0][k] <= '0;
         end
      end
   end

   for (genvar j = 1; j <= QB; j++) begin : g_step
      localparam int BIT = QB - j;
      logic [RW:0]   diff [L];
      logic [RW-1:0] rem_in [L];
      logic [QB-1:0] quo_in [L];

      always_comb begin
         for (int k = 0; k < L; k++) begin
            diff[k] = {1'b0, rem_ff[j-1][k]} - {1'b0, RW'(dmag_ff[j-1]) << BIT};
            if (!diff[k][RW]) begin
               rem_in[k] = diff[k][RW-1:0];
               quo_in[k] = quo_ff[j-1][k] | (QB'(1) << BIT);
            end else begin
               rem_in[k] = rem_ff[j-1][k];
               quo_in[k] = quo_ff[j-1][k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (enable) begin
            ctl_ff[j] <= ctl_ff[j-1];
         end
         if (enable) begin
            ovf_ff[j] <= ovf_ff[j-1];
            for (int k = 0; k < L; k++) begin
               rem_ff[j][k] <= rem_in[k];
               quo_ff[j][k] <= quo_in[k];
            end
         end
      end

      if (j < QB) begin : g_dmag
         always_ff @(posedge clock) begin
            if (enable) begin
               dmag_ff[j] <= dmag_ff[j-1];
            end
         end
      end
   end

   assign ctl_out = ctl_ff[QB];
   assign ovf_out = ovf_ff[QB];
   always_comb begin
      for (int k = 0; k < L; k++) begin
         quo_out[k] = quo_ff[QB][k];
      end
   end

   // lane 0, without overflow, ends with a partial remainder below the divisor
   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      ctl_ff[QB-1].valid && !ctl_ff[QB-1].singular && !ovf_ff[QB-1][0] && enable
      |=> rem_ff[QB][0] < RW'($past(dmag_ff[QB-1])))
      else $error("divider remainder not reduced");

   a_valid_moves: assert property (@(posedge clock) disable iff (reset)
      enable && ctl_ff[QB-1].valid |=> ctl_ff[QB].valid)
      else $error("divider lost a transaction");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !enable |=> $stable(quo_ff[QB][0]) && $stable(ctl_ff[QB]))
      else $error("divider output moved while held");

endmodule

// ===== rtl/core/matrix_inverse_3x3.sv =====
// matrix_inverse_3x3: top level, adjugate/determinant front end and
// saturating output stage. Depends on mi3_pkg and mi3_div_pipe.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_m00 .. req_m22
//   rsp      out        rsp_valid/rsp_stall  rsp_inv00 .. rsp_inv22, singular, saturated
//
// one transaction per cycle while rsp_stall does not hold the pipeline;
// six front-end stages, DATA_WIDTH + 2 divider stages (an overflow check,
// then one quotient bit each) and the output register.
// reset clears all valid bits; payload registers are not reset.
// a stalled result freezes the whole pipeline, so req_stall follows it.
module matrix_inverse_3x3 #(
   parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF,
   parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [mi3_pkg::PORT_W-1:0] req_m00,
   input  logic [mi3_pkg::PORT_W-1:0] req_m01,
   input  logic [mi3_pkg::PORT_W-1:0] req_m02,
   input  logic [mi3_pkg::PORT_W-1:0] req_m10,
   input  logic [mi3_pkg::PORT_W-1:0] req_m11,
   input  logic [mi3_pkg::PORT_W-1:0] req_m12,
   input  logic [mi3_pkg::PORT_W-1:0] req_m20,
   input  logic [mi3_pkg::PORT_W-1:0] req_m21,
   input  logic [mi3_pkg::PORT_W-1:0] req_m22,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv00,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv01,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv02,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv10,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv11,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv12,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv20,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv21,
   output logic [mi3_pkg::PORT_W-1:0] rsp_inv22,
   output logic                       rsp_singular,
   output logic                       rsp_saturated
);

   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2 * DW;
   localparam int AW  = 2 * DW + 1;
   localparam int PPW = 2 * DW + 2;
   localparam int TW  = 3 * DW + 1;
   localparam int MW  = 3 * DW;
   localparam int NW  = 2 * DW;
   localparam int QB  = DW + 1;
   localparam int OW  = mi3_pkg::PORT_W;
   localparam int L   = mi3_pkg::LANES;

   logic enable;
   logic rsp_valid_ff;

   assign enable    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !enable;

   logic signed [DW-1:0] m [L];
   assign m[0] = $signed(req_m00[DW-1:0]);
   assign m[1] = $signed(req_m01[DW-1:0]);
   assign m[2] = $signed(req_m02[DW-1:0]);
   assign m[3] = $signed(req_m10[DW-1:0]);
   assign m[4] = $signed(req_m11[DW-1:0]);
   assign m[5] = $signed(req_m12[DW-1:0]);
   assign m[6] = $signed(req_m20[DW-1:0]);
   assign m[7] = $signed(req_m21[DW-1:0]);
   assign m[8] = $signed(req_m22[DW-1:0]);

   // stage 1: element products
   logic                 s1_valid_ff;
   logic signed [PW-1:0] s1_pa_ff [L];
   logic signed [PW-1:0] s1_pb_ff [L];
   logic signed [DW-1:0] s1_m_ff  [3];
   // stage 2: cofactors
   logic                 s2_valid_ff;
   logic signed [AW-1:0] s2_adj_ff [L];
   logic signed [DW-1:0] s2_m_ff   [3];
   // stage 3: split partial products of the first-column terms
   logic                  s3_valid_ff;
   logic signed [AW-1:0]  s3_adj_ff [L];
   logic signed [PPW-1:0] s3_pl_ff  [3];
   logic signed [PPW-1:0] s3_ph_ff  [3];
   // stage 4: first-column terms
   logic                 s4_valid_ff;
   logic signed [AW-1:0] s4_adj_ff  [L];
   logic signed [TW-1:0] s4_term_ff [3];
   // stage 5: determinant
   logic                 s5_valid_ff;
   logic signed [AW-1:0] s5_adj_ff [L];
   logic signed [TW-1:0] s5_det_ff;
   // stage 6: magnitudes and signs for the divider
   mi3_pkg::mi3_ctl_type s6_ctl_ff;
   logic [MW-1:0]        s6_dmag_ff;
   logic [NW-1:0]        s6_num_ff [L];

   logic signed [PW-1:0]  s1_pa_in [L];
   logic signed [PW-1:0]  s1_pb_in [L];
   logic signed [PPW-1:0] s3_pl_in [3];
   logic signed [PPW-1:0] s3_ph_in [3];
   logic signed [DW:0]    adj_lo   [3];
   logic signed [DW:0]    adj_hi   [3];
   logic signed [TW-1:0]  s4_term_in [3];
   mi3_pkg::mi3_ctl_type  s6_ctl_in;
   logic [NW-1:0]         s6_num_in [L];
   logic                  det_neg;

   always_comb begin
      for (int k = 0; k < L; k++) begin
         s1_pa_in[k] = PW'(m[mi3_pkg::COF_IDX[k][0]]) * PW'(m[mi3_pkg::COF_IDX[k][1]]);
         s1_pb_in[k] = PW'(m[mi3_pkg::COF_IDX[k][2]]) * PW'(m[mi3_pkg::COF_IDX[k][3]]);
      end
      for (int k = 0; k < 3; k++) begin
         adj_lo[k]     = $signed({1'b0, s2_adj_ff[k][DW-1:0]});
         adj_hi[k]     = $signed(s2_adj_ff[k][AW-1:DW]);
         s3_pl_in[k]   = PPW'(adj_lo[k]) * PPW'(s2_m_ff[k]);
         s3_ph_in[k]   = PPW'(adj_hi[k]) * PPW'(s2_m_ff[k]);
         s4_term_in[k] = (TW'(s3_ph_ff[k]) <<< DW) + TW'(s3_pl_ff[k]);
      end
      det_neg              = s5_det_ff[TW-1];
      s6_ctl_in.valid      = s5_valid_ff;
      s6_ctl_in.singular   = s5_det_ff == '0;
      for (int k = 0; k < L; k++) begin
         s6_ctl_in.neg[k] = s5_adj_ff[k][AW-1] ^ det_neg;
         s6_num_in[k]     = NW'(s5_adj_ff[k][AW-1] ? -s5_adj_ff[k] : s5_adj_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_ctl_ff   <= '0;
      end else if (enable) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         s6_ctl_ff   <= s6_ctl_in;
      end
      if (enable) begin
         for (int k = 0; k < L; k++) begin
            s1_pa_ff[k]  <= s1_pa_in[k];
            s1_pb_ff[k]  <= s1_pb_in[k];
            s2_adj_ff[k] <= AW'(s1_pa_ff[k]) - AW'(s1_pb_ff[k]);
            s3_adj_ff[k] <= s2_adj_ff[k];
            s4_adj_ff[k] <= s3_adj_ff[k];
            s5_adj_ff[k] <= s4_adj_ff[k];
            s6_num_ff[k] <= s6_num_in[k];
         end
         for (int k = 0; k < 3; k++) begin
            s1_m_ff[k]    <= m[mi3_pkg::DET_IDX[k]];
            s2_m_ff[k]    <= s1_m_ff[k];
            s3_pl_ff[k]   <= s3_pl_in[k];
            s3_ph_ff[k]   <= s3_ph_in[k];
            s4_term_ff[k] <= s4_term_in[k];
         end
         s5_det_ff  <= s4_term_ff[0] + s4_term_ff[1] + s4_term_ff[2];
         s6_dmag_ff <= MW'(det_neg ? -s5_det_ff : s5_det_ff);
      end
   end

   mi3_pkg::mi3_ctl_type div_ctl;
   logic [QB-1:0]        div_quo [L];
   logic [L-1:0]         div_ovf;

   mi3_div_pipe #(
      .DATA_WIDTH (DATA_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .enable  (enable),
      .ctl_in  (s6_ctl_ff),
      .dmag_in (s6_dmag_ff),
      .num_in  (s6_num_ff),
      .ctl_out (div_ctl),
      .quo_out (div_quo),
      .ovf_out (div_ovf)
   );

   // saturate, apply sign, zero out singular results
   logic [QB-1:0]        pos_max;
   logic [QB-1:0]        neg_mag;
   logic [L-1:0]         lane_sat;
   logic [QB-1:0]        lane_mag [L];
   logic signed [DW-1:0] lane_val [L];
   logic [OW-1:0]        inv_in   [L];
   logic [OW-1:0]        inv_ff   [L];
   logic                 singular_ff;
   logic                 saturated_ff;

   always_comb begin
      neg_mag = QB'(1) << (DW - 1);
      pos_max = neg_mag - QB'(1);
      for (int k = 0; k < L; k++) begin
         if (div_ctl.neg[k]) begin
            lane_sat[k] = div_ovf[k] || (div_quo[k] > neg_mag);
            lane_mag[k] = lane_sat[k] ? neg_mag : div_quo[k];
            lane_val[k] = -$signed(lane_mag[k][DW-1:0]);
         end else begin
            lane_sat[k] = div_ovf[k] || (div_quo[k] > pos_max);
            lane_mag[k] = lane_sat[k] ? pos_max : div_quo[k];
            lane_val[k] = $signed(lane_mag[k][DW-1:0]);
         end
         inv_in[k] = div_ctl.singular ? '0 : OW'(lane_val[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= div_ctl.valid;
      end
      if (enable) begin
         for (int k = 0; k < L; k++) begin
            inv_ff[k] <= inv_in[k];
         end
         singular_ff  <= div_ctl.singular;
         saturated_ff <= !div_ctl.singular && (lane_sat != '0);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_inv00     = inv_ff[0];
   assign rsp_inv01     = inv_ff[1];
   assign rsp_inv02     = inv_ff[2];
   assign rsp_inv10     = inv_ff[3];
   assign rsp_inv11     = inv_ff[4];
   assign rsp_inv12     = inv_ff[5];
   assign rsp_inv20     = inv_ff[6];
   assign rsp_inv21     = inv_ff[7];
   assign rsp_inv22     = inv_ff[8];
   assign rsp_singular  = singular_ff;
   assign rsp_saturated = saturated_ff;

   a_singular_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && singular_ff |-> !saturated_ff && (inv_ff[0] == '0)
         && (inv_ff[4] == '0) && (inv_ff[8] == '0))
      else $error("singular result not cleared");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && !s6_ctl_ff.valid)
      else $error("pipeline not empty after reset");

   a_sat_clipped: assert property (@(posedge clock) disable iff (reset)
      enable && div_ctl.valid && !div_ctl.singular && !div_ovf[0] && !lane_sat[0]
      |=> inv_ff[0] == OW'($signed($past(lane_val[0]))))
      else $error("unclipped lane changed value");

endmodule
